/* rtl/vhfc_pkg.sv */
// Shared constants, types and helpers for the voxel hidden-face cull block.
// Used by vhfc_occ_store, voxel_hidden_face_cull and the testbench; depends on nothing.
package vhfc_pkg;

   localparam int CHUNK_SIZE   = 16;
   localparam int CHUNK_HEIGHT = 16;

   // chunk plus the one-cell border shell
   localparam int SPAN_XZ   = CHUNK_SIZE + 2;
   localparam int SPAN_Y    = CHUNK_HEIGHT + 2;
   // one memory row holds every z cell of one (x, y) column
   localparam int ROW_COUNT = SPAN_XZ * SPAN_Y;
   localparam int ROW_AW    = $clog2(ROW_COUNT);
   localparam int XW        = $clog2(SPAN_XZ);
   localparam int YW        = $clog2(SPAN_Y);

   localparam int VC_W = 17;
   localparam logic [VC_W-1:0] VC_MAX = {VC_W{1'b1}};
   localparam logic [VC_W-1:0] VC_STEP = VC_W'(4);

   localparam int FACE_COUNT = 6;

   localparam logic [1:0] MODE_WRITE    = 2'd0;
   localparam logic [1:0] MODE_QUERY    = 2'd1;
   localparam logic [1:0] MODE_CLEAR_VC = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_RD,
      ST_WR_WR,
      ST_Q_RD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                rd_en;
      logic [ROW_AW-1:0]   rd_addr;
      logic                wr_en;
      logic [ROW_AW-1:0]   wr_addr;
      logic [SPAN_XZ-1:0]  wr_data;
   } mem_req_type;

   // row = (x+1) * SPAN_Y + (y+1), offsets already include the +1
   function automatic logic [ROW_AW-1:0] row_addr(input logic [XW-1:0] xo,
                                                  input logic [YW-1:0] yo);
      logic [15:0] s;
      s = 16'(xo) * 16'(SPAN_Y) + 16'(yo);
      return s[ROW_AW-1:0];
   endfunction

endpackage

/* rtl/voxel_hidden_face_cull.sv */
// Voxel hidden-face cull, top level.
// Request channel (req_*): one request per handshake. tuser carries the mode:
// write cell, query voxel faces, or clear the vertex count. tdata carries the
// cell position (signed, -1 and the chunk size are the border shell) and the
// solid bit for writes.
// Response channel (rsp_*): a query on a solid chunk voxel yields one response
// per exposed face, in the order top, bottom, right, left, front, back, each
// with its base vertex index; tlast marks the final one. Other requests and
// hidden or empty voxels yield nothing.
// Timing: one request at a time, accepted in the idle state. A vertex clear, an
// ignored request or a query outside the chunk ends there; a cell write runs
// accept, row read, write back. A query runs its column reads (center, up,
// down, right, left), then emits one face per cycle while rsp_tready keeps up;
// the single store read port sets this pace.
// Reset: synchronous. After reset a clearing pass writes the 324 store rows
// to empty, one row a cycle, with req_tready low throughout the pass.
// Stalls: the response register holds while rsp_tready is low; a new request
// is taken once the current one has handed off its last response to that
// register, even if that response is still waiting.
module voxel_hidden_face_cull (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pos_x[5:0], pos_y[11:6], pos_z[17:12], solid[18]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // face_dir[2:0], base_vertex[19:3]
   output logic        rsp_tuser,   // face_present[0]
   output logic        rsp_tlast
);

   localparam int XW = vhfc_pkg::XW;
   localparam int YW = vhfc_pkg::YW;
   localparam int AW = vhfc_pkg::ROW_AW;

   // read sequence steps during a query
   localparam logic [2:0] RD_CENTER = 3'd0;
   localparam logic [2:0] RD_UP     = 3'd1;
   localparam logic [2:0] RD_DOWN   = 3'd2;
   localparam logic [2:0] RD_RIGHT  = 3'd3;
   localparam logic [2:0] RD_LEFT   = 3'd4;
   localparam logic [2:0] RD_DONE   = 3'd5;

   localparam int FACE_TOP    = 0;
   localparam int FACE_BOTTOM = 1;
   localparam int FACE_RIGHT  = 2;
   localparam int FACE_LEFT   = 3;
   localparam int FACE_FRONT  = 4;
   localparam int FACE_BACK   = 5;

   vhfc_pkg::state_type state_ff, state_in;
   logic [AW-1:0]        clr_addr_ff, clr_addr_in;
   logic [XW-1:0]        xo_ff, xo_in;
   logic [YW-1:0]        yo_ff, yo_in;
   logic [XW-1:0]        zo_ff, zo_in;
   logic                 solid_ff, solid_in;
   logic [2:0]           rd_idx_ff, rd_idx_in;
   logic                 center_ff, center_in;
   logic [vhfc_pkg::FACE_COUNT-1:0] nb_ff, nb_in;
   logic [vhfc_pkg::FACE_COUNT-1:0] faces_ff, faces_in;
   logic [vhfc_pkg::VC_W-1:0] vcount_ff, vcount_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_dir_ff, rsp_dir_in;
   logic [vhfc_pkg::VC_W-1:0] rsp_base_ff, rsp_base_in;
   logic                 rsp_last_ff, rsp_last_in;

   vhfc_pkg::mem_req_type         mem_req;
   logic [vhfc_pkg::SPAN_XZ-1:0]  rd_data;

   logic signed [5:0] req_x, req_y, req_z;
   logic [1:0]        req_mode;
   logic              req_accept;
   logic              req_in_shell, req_in_chunk;
   logic              rsp_free, rsp_load;
   logic [2:0]        pick_dir;
   logic [vhfc_pkg::FACE_COUNT-1:0] faces_rest;
   logic [XW-1:0]     z_front, z_back;
   logic              clear_done;

   vhfc_occ_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign req_mode = req_tuser;
   assign req_x    = $signed(req_tdata[5:0]);
   assign req_y    = $signed(req_tdata[11:6]);
   assign req_z    = $signed(req_tdata[17:12]);

   assign req_tready = (state_ff == vhfc_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign req_in_shell = (req_x >= -1) && (req_x <= vhfc_pkg::CHUNK_SIZE) &&
                         (req_y >= -1) && (req_y <= vhfc_pkg::CHUNK_HEIGHT) &&
                         (req_z >= -1) && (req_z <= vhfc_pkg::CHUNK_SIZE);
   assign req_in_chunk = (req_x >= 0) && (req_x < vhfc_pkg::CHUNK_SIZE) &&
                         (req_y >= 0) && (req_y < vhfc_pkg::CHUNK_HEIGHT) &&
                         (req_z >= 0) && (req_z < vhfc_pkg::CHUNK_SIZE);

   assign clear_done = (clr_addr_ff == AW'(vhfc_pkg::ROW_COUNT - 1));
   assign z_front    = zo_ff + XW'(1);
   assign z_back     = zo_ff - XW'(1);

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // lowest pending face, and what stays after it is taken
   always_comb begin
      pick_dir = 3'd0;
      for (int i = vhfc_pkg::FACE_COUNT - 1; i >= 0; i--) begin
         if (faces_ff[i]) begin
            pick_dir = 3'(i);
         end
      end
   end
   assign faces_rest = faces_ff & (faces_ff - 1'b1);
   assign rsp_load   = (state_ff == vhfc_pkg::ST_EMIT) && (faces_ff != '0) && rsp_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vhfc_pkg::ST_CLEAR: begin
            if (clear_done) begin
               state_in = vhfc_pkg::ST_IDLE;
            end
         end
         vhfc_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_mode == vhfc_pkg::MODE_WRITE && req_in_shell) begin
                  state_in = vhfc_pkg::ST_WR_RD;
               end else if (req_mode == vhfc_pkg::MODE_QUERY && req_in_chunk) begin
                  state_in = vhfc_pkg::ST_Q_RD;
               end
            end
         end
         vhfc_pkg::ST_WR_RD: state_in = vhfc_pkg::ST_WR_WR;
         vhfc_pkg::ST_WR_WR: state_in = vhfc_pkg::ST_IDLE;
         vhfc_pkg::ST_Q_RD: begin
            if (rd_idx_ff == RD_DONE) begin
               state_in = vhfc_pkg::ST_EMIT;
            end
         end
         vhfc_pkg::ST_EMIT: begin
            if (faces_ff == '0 || (rsp_load && faces_rest == '0)) begin
               state_in = vhfc_pkg::ST_IDLE;
            end
         end
         default: state_in = vhfc_pkg::ST_CLEAR;
      endcase
   end

   // store port and datapath
   always_comb begin
      mem_req      = '0;
      clr_addr_in  = clr_addr_ff;
      xo_in        = xo_ff;
      yo_in        = yo_ff;
      zo_in        = zo_ff;
      solid_in     = solid_ff;
      rd_idx_in    = rd_idx_ff;
      center_in    = center_ff;
      nb_in        = nb_ff;
      faces_in     = faces_ff;
      vcount_in    = vcount_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_dir_in   = rsp_dir_ff;
      rsp_base_in  = rsp_base_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         vhfc_pkg::ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_addr_ff;
            clr_addr_in     = clr_addr_ff + AW'(1);
         end
         vhfc_pkg::ST_IDLE: begin
            xo_in     = XW'(7'(req_x) + 7'd1);
            yo_in     = YW'(7'(req_y) + 7'd1);
            zo_in     = XW'(7'(req_z) + 7'd1);
            solid_in  = req_tdata[18];
            rd_idx_in = RD_CENTER;
            if (req_accept && req_mode == vhfc_pkg::MODE_CLEAR_VC) begin
               vcount_in = '0;
            end
         end
         vhfc_pkg::ST_WR_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = vhfc_pkg::row_addr(xo_ff, yo_ff);
         end
         vhfc_pkg::ST_WR_WR: begin
            mem_req.wr_en          = 1'b1;
            mem_req.wr_addr        = vhfc_pkg::row_addr(xo_ff, yo_ff);
            mem_req.wr_data        = rd_data;
            mem_req.wr_data[zo_ff] = solid_ff;
         end
         vhfc_pkg::ST_Q_RD: begin
            rd_idx_in = rd_idx_ff + 3'd1;
            case (rd_idx_ff)
               RD_CENTER: begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = vhfc_pkg::row_addr(xo_ff, yo_ff);
               end
               RD_UP: begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = vhfc_pkg::row_addr(xo_ff, yo_ff + YW'(1));
                  // data now on rd_data is the center column
                  center_in         = rd_data[zo_ff];
                  nb_in[FACE_FRONT] = rd_data[z_front];
                  nb_in[FACE_BACK]  = rd_data[z_back];
               end
               RD_DOWN: begin
                  mem_req.rd_en      = 1'b1;
                  mem_req.rd_addr    = vhfc_pkg::row_addr(xo_ff, yo_ff - YW'(1));
                  nb_in[FACE_TOP]    = rd_data[zo_ff];
               end
               RD_RIGHT: begin
                  mem_req.rd_en      = 1'b1;
                  mem_req.rd_addr    = vhfc_pkg::row_addr(xo_ff + XW'(1), yo_ff);
                  nb_in[FACE_BOTTOM] = rd_data[zo_ff];
               end
               RD_LEFT: begin
                  mem_req.rd_en      = 1'b1;
                  mem_req.rd_addr    = vhfc_pkg::row_addr(xo_ff - XW'(1), yo_ff);
                  nb_in[FACE_RIGHT]  = rd_data[zo_ff];
               end
               RD_DONE: begin
                  nb_in[FACE_LEFT] = rd_data[zo_ff];
                  faces_in = ~nb_in & {vhfc_pkg::FACE_COUNT{center_ff}};
               end
               default: rd_idx_in = RD_CENTER;
            endcase
         end
         vhfc_pkg::ST_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_dir_in   = pick_dir;
               rsp_base_in  = vcount_ff;
               rsp_last_in  = (faces_rest == '0);
               faces_in     = faces_rest;
               vcount_in    = (vcount_ff > vhfc_pkg::VC_MAX - vhfc_pkg::VC_STEP) ?
                              vhfc_pkg::VC_MAX : vcount_ff + vhfc_pkg::VC_STEP;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vhfc_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         faces_ff     <= '0;
         vcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rd_idx_ff    <= RD_CENTER;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         faces_ff     <= faces_in;
         vcount_ff    <= vcount_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_idx_ff    <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      xo_ff       <= xo_in;
      yo_ff       <= yo_in;
      zo_ff       <= zo_in;
      solid_ff    <= solid_in;
      center_ff   <= center_in;
      nb_ff       <= nb_in;
      rsp_dir_ff  <= rsp_dir_in;
      rsp_base_ff <= rsp_base_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_base_ff, rsp_dir_ff};
   assign rsp_tuser  = 1'b1;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // no store write may land while a query is reading its columns
   a_no_write_in_query: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vhfc_pkg::ST_Q_RD) |-> !mem_req.wr_en)
      else $error("store write during query read sequence");

   // a new request is only taken once all faces of the last query are handed off
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (faces_ff == '0))
      else $error("request accepted with faces still pending");

   // emitting a face never lowers the vertex count and leaves the response valid
   a_vcount_grows: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (vcount_ff >= $past(vcount_ff)) && rsp_tvalid)
      else $error("vertex count dropped or response lost on face load");

   // reset always starts the clearing pass
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (state_ff == vhfc_pkg::ST_CLEAR) && (clr_addr_ff == '0))
      else $error("reset did not start the clearing pass");
`endif

endmodule

/* rtl/vhfc_occ_store.sv */
// Occupancy store: one row of SPAN_XZ bits per (x, y) column, one write and
// one registered read per cycle. Depends on vhfc_pkg.
module vhfc_occ_store (
   input  logic                         clock,
   input  vhfc_pkg::mem_req_type        mem_req,
   output logic [vhfc_pkg::SPAN_XZ-1:0] rd_data
);

   logic [vhfc_pkg::SPAN_XZ-1:0] mem [vhfc_pkg::ROW_COUNT];
   logic [vhfc_pkg::SPAN_XZ-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* dv/voxel_hidden_face_cull_test.sv */
// Testbench for voxel_hidden_face_cull: drives cell writes, face queries and vertex clears
// on the request stream, predicts the face responses and checks each one by field.
// Depends on vhfc_pkg and the voxel_hidden_face_cull top level only.
`timescale 1ns / 100ps

module voxel_hidden_face_cull_test;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CELL_TOTAL  = vhfc_pkg::SPAN_XZ * vhfc_pkg::SPAN_Y * vhfc_pkg::SPAN_XZ;
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 200;
   localparam int BURST_QUERIES = 16;   // back-to-back six-face queries
   localparam int BATCH_COUNT = 4;
   localparam int BATCH_ITEMS = 108;

   typedef enum logic [2:0] {
      FACE_TOP, FACE_BOTTOM, FACE_RIGHT, FACE_LEFT, FACE_FRONT, FACE_BACK
   } face_dir_type;

   typedef struct {
      logic [1:0]        mode;
      logic signed [5:0] px;
      logic signed [5:0] py;
      logic signed [5:0] pz;
      logic              solid;
   } vox_req_type;

   typedef struct {
      logic        present;
      logic [2:0]  dir;
      logic [16:0] base;
      logic        last;
   } face_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   voxel_hidden_face_cull i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // predictor state
   bit          occ_map [0:CELL_TOTAL-1];
   logic [16:0] vert_count = '0;

   vox_req_type  req_queue [$];
   face_rsp_type face_q [$];
   vox_req_type  req_cur;

   bit req_done = 1'b0;
   bit rsp_done = 1'b0;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   bit hold_req = 1'b0;
   int req_wait = 0;
   int rsp_wait = 0;
   int hold_left = 0;

   int errors = 0;
   int n_writes = 0, n_queries = 0, n_clears = 0, n_other = 0;
   int n_faces = 0;
   int stall_count = 0;

   function automatic bit in_shell(int x, int y, int z);
      return x >= -1 && x <= vhfc_pkg::CHUNK_SIZE && y >= -1 &&
             y <= vhfc_pkg::CHUNK_HEIGHT && z >= -1 && z <= vhfc_pkg::CHUNK_SIZE;
   endfunction

   function automatic int cell_idx(int x, int y, int z);
      return ((x + 1) * vhfc_pkg::SPAN_Y + (y + 1)) * vhfc_pkg::SPAN_XZ + (z + 1);
   endfunction

   function automatic bit cell_at(int x, int y, int z);
      if (!in_shell(x, y, z)) return 1'b0;
      return occ_map[cell_idx(x, y, z)];
   endfunction

   // apply one request to the shadow store and queue the faces it exposes
   task automatic predict_faces(input vox_req_type it);
      int x, y, z, nx, ny, nz, n;
      face_dir_type fd;
      face_rsp_type hits [0:5];
      x = it.px;
      y = it.py;
      z = it.pz;
      n = 0;
      case (it.mode)
         vhfc_pkg::MODE_WRITE: begin
            if (in_shell(x, y, z)) occ_map[cell_idx(x, y, z)] = it.solid;
         end
         vhfc_pkg::MODE_CLEAR_VC: begin
            vert_count = '0;
         end
         vhfc_pkg::MODE_QUERY: begin
            if (x >= 0 && x < vhfc_pkg::CHUNK_SIZE && y >= 0 && y < vhfc_pkg::CHUNK_HEIGHT &&
                z >= 0 && z < vhfc_pkg::CHUNK_SIZE && cell_at(x, y, z)) begin
               for (int d = 0; d < vhfc_pkg::FACE_COUNT; d++) begin
                  fd = face_dir_type'(d);
                  nx = x;
                  ny = y;
                  nz = z;
                  case (fd)
                     FACE_TOP:    ny = y + 1;
                     FACE_BOTTOM: ny = y - 1;
                     FACE_RIGHT:  nx = x + 1;
                     FACE_LEFT:   nx = x - 1;
                     FACE_FRONT:  nz = z + 1;
                     default:     nz = z - 1;
                  endcase
                  if (!cell_at(nx, ny, nz)) begin
                     hits[n].present = 1'b1;
                     hits[n].dir = fd;
                     hits[n].base = vert_count;
                     hits[n].last = 1'b0;
                     vert_count = (vert_count > vhfc_pkg::VC_MAX - vhfc_pkg::VC_STEP) ?
                                  vhfc_pkg::VC_MAX : vert_count + vhfc_pkg::VC_STEP;
                     n++;
                  end
               end
               for (int i = 0; i < n; i++) begin
                  hits[i].last = (i == n - 1);
                  face_q.insert(face_q.size(), hits[i]);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic push_req(input logic [1:0] mode, input int x, input int y, input int z,
                           input bit solid);
      vox_req_type it;
      it.mode = mode;
      it.px = x[5:0];
      it.py = y[5:0];
      it.pz = z[5:0];
      it.solid = solid;
      req_queue.insert(req_queue.size(), it);
   endtask

   // sender stays quiet until every queued request went out and every face came back
   task automatic wait_drained();
      while (req_queue.size() != 0 || req_tvalid || face_q.size() != 0)
         @(posedge clock);
   endtask

   function automatic int rand_coord(int sel, int size);
      case (sel)
         0: return $urandom_range(0, 4) - 1;
         1: return size - 4 + $urandom_range(0, 4);
         2: return $urandom_range(0, size + 1) - 1;
         default: return size / 2 - 2 + $urandom_range(0, 3);
      endcase
   endfunction

   task automatic push_random();
      int r, sel;
      r = $urandom_range(0, 99);
      sel = $urandom_range(0, 3);
      if (r < 45)
         push_req(vhfc_pkg::MODE_WRITE, rand_coord(sel, vhfc_pkg::CHUNK_SIZE),
                  rand_coord(sel, vhfc_pkg::CHUNK_HEIGHT),
                  rand_coord(sel, vhfc_pkg::CHUNK_SIZE), $urandom_range(0, 9) < 7);
      else if (r < 85)
         push_req(vhfc_pkg::MODE_QUERY, rand_coord(sel, vhfc_pkg::CHUNK_SIZE),
                  rand_coord(sel, vhfc_pkg::CHUNK_HEIGHT),
                  rand_coord(sel, vhfc_pkg::CHUNK_SIZE), $urandom_range(0, 1));
      else if (r < 88)
         push_req(vhfc_pkg::MODE_CLEAR_VC, $urandom, $urandom, $urandom,
                  $urandom_range(0, 1));
      else if (r < 92)
         push_req(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom_range(0, 1));
      else
         // raw 6-bit positions, mostly outside the shell
         push_req($urandom_range(0, 1) ? vhfc_pkg::MODE_WRITE : vhfc_pkg::MODE_QUERY,
                  $urandom, $urandom, $urandom, $urandom_range(0, 1));
   endtask

   // request driver
   always @(negedge clock) begin
      logic nv;
      nv = req_tvalid;
      if (!reset) begin
         if (req_done) begin
            req_done = 1'b0;
            req_wait = req_idle_on ? $urandom_range(0, 12) : 0;
            nv = 1'b0;
         end
         if (!nv) begin
            if (req_wait > 0) begin
               req_wait--;
            end else if (req_queue.size() != 0) begin
               req_cur = req_queue.pop_front();
               req_tdata <= {5'd0, req_cur.solid, req_cur.pz, req_cur.py, req_cur.px};
               req_tuser <= req_cur.mode;
               nv = 1'b1;
            end
         end
      end
      req_tvalid <= nv;
   end

   // response receiver, with a long hold-off on request
   always @(negedge clock) begin
      logic rdy;
      rdy = 1'b0;
      if (!reset) begin
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (rsp_done) begin
            rsp_done = 1'b0;
            rsp_wait = rsp_idle_on ? $urandom_range(0, 12) : 0;
         end
         if (hold_left > 0) hold_left--;
         else if (rsp_wait > 0) rsp_wait--;
         else rdy = 1'b1;
      end
      rsp_tready <= rdy;
   end

   // monitor: predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      face_rsp_type e;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_done = 1'b1;
            case (req_cur.mode)
               vhfc_pkg::MODE_WRITE:    n_writes++;
               vhfc_pkg::MODE_QUERY:    n_queries++;
               vhfc_pkg::MODE_CLEAR_VC: n_clears++;
               default:                 n_other++;
            endcase
            predict_faces(req_cur);
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_done = 1'b1;
            n_faces++;
            if (face_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, got dir %0d base %0d",
                        $time, rsp_tdata[2:0], rsp_tdata[19:3]);
               errors++;
            end else begin
               e = face_q.pop_front();
               if (rsp_tuser !== e.present) begin
                  $display("%0t: face_present expected %0d, got %0d", $time, e.present,
                           rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[2:0] !== e.dir) begin
                  $display("%0t: face_dir expected %0d, got %0d", $time, e.dir,
                           rsp_tdata[2:0]);
                  errors++;
               end
               if (rsp_tdata[19:3] !== e.base) begin
                  $display("%0t: base_vertex expected %0d, got %0d", $time, e.base,
                           rsp_tdata[19:3]);
                  errors++;
               end
               if (rsp_tlast !== e.last) begin
                  $display("%0t: last expected %0d, got %0d", $time, e.last, rsp_tlast);
                  errors++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_count = 0;
         else stall_count++;
         if (stall_count >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
                     $time, stall_count, face_q.size());
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: lone voxel, partial and full hiding, shell, ignored requests
      push_req(vhfc_pkg::MODE_QUERY, 0, 0, 0, 1'b1);            // empty voxel
      push_req(vhfc_pkg::MODE_WRITE, 5, 5, 5, 1'b1);
      push_req(vhfc_pkg::MODE_QUERY, 5, 5, 5, 1'b0);            // six faces
      push_req(vhfc_pkg::MODE_WRITE, 5, 6, 5, 1'b1);
      push_req(vhfc_pkg::MODE_QUERY, 5, 5, 5, 1'b0);            // top hidden
      push_req(vhfc_pkg::MODE_WRITE, 5, 4, 5, 1'b1);
      push_req(vhfc_pkg::MODE_WRITE, 6, 5, 5, 1'b1);
      push_req(vhfc_pkg::MODE_WRITE, 4, 5, 5, 1'b1);
      push_req(vhfc_pkg::MODE_WRITE, 5, 5, 6, 1'b1);
      push_req(vhfc_pkg::MODE_WRITE, 5, 5, 4, 1'b1);
      push_req(vhfc_pkg::MODE_QUERY, 5, 5, 5, 1'b0);            // fully hidden
      push_req(vhfc_pkg::MODE_WRITE, 16, 15, 15, 1'b1);         // shell cell
      push_req(vhfc_pkg::MODE_WRITE, 15, 15, 15, 1'b1);
      push_req(vhfc_pkg::MODE_QUERY, 15, 15, 15, 1'b0);         // right hidden by shell
      push_req(vhfc_pkg::MODE_QUERY, 16, 15, 15, 1'b0);         // query on shell
      push_req(vhfc_pkg::MODE_WRITE, 31, -32, 20, 1'b1);        // outside shell, dropped
      push_req(vhfc_pkg::MODE_QUERY, -32, 31, -17, 1'b1);
      push_req(MODE_UNUSED, 5, 5, 5, 1'b1);
      push_req(vhfc_pkg::MODE_CLEAR_VC, 0, 0, 0, 1'b0);
      push_req(vhfc_pkg::MODE_WRITE, -1, -1, -1, 1'b1);
      push_req(vhfc_pkg::MODE_WRITE, 0, 0, 0, 1'b1);
      push_req(vhfc_pkg::MODE_QUERY, 0, 0, 0, 1'b0);
      push_req(vhfc_pkg::MODE_WRITE, 5, 6, 5, 1'b0);            // clear a neighbor
      push_req(vhfc_pkg::MODE_QUERY, 5, 5, 5, 1'b0);
      wait_drained();

      // back-to-back queries on an isolated voxel, no idling
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      push_req(vhfc_pkg::MODE_CLEAR_VC, 0, 0, 0, 1'b0);
      push_req(vhfc_pkg::MODE_WRITE, 10, 3, 10, 1'b1);
      push_req(vhfc_pkg::MODE_WRITE, 10, 4, 10, 1'b0);
      push_req(vhfc_pkg::MODE_WRITE, 10, 2, 10, 1'b0);
      push_req(vhfc_pkg::MODE_WRITE, 11, 3, 10, 1'b0);
      push_req(vhfc_pkg::MODE_WRITE, 9, 3, 10, 1'b0);
      push_req(vhfc_pkg::MODE_WRITE, 10, 3, 11, 1'b0);
      push_req(vhfc_pkg::MODE_WRITE, 10, 3, 9, 1'b0);
      for (int i = 0; i < BURST_QUERIES; i++) push_req(vhfc_pkg::MODE_QUERY, 10, 3, 10, 1'b0);
      push_req(vhfc_pkg::MODE_CLEAR_VC, 0, 0, 0, 1'b0);
      wait_drained();

      for (int b = 0; b < BATCH_COUNT; b++) begin
         req_idle_on = (b != 1);
         rsp_idle_on = (b == 0 || b == 2);
         // receiver holds off while the sender keeps offering
         if (b == 2) hold_req = 1'b1;
         for (int i = 0; i < BATCH_ITEMS; i++) push_random();
         wait_drained();
      end

      repeat (40) @(posedge clock);
      $display("Covered %0d writes, %0d queries, %0d vertex clears, %0d ignored modes;",
               n_writes, n_queries, n_clears, n_other);
      $display("checked %0d face responses under idle, burst and long receiver stalls.",
               n_faces);
      if (errors == 0 && face_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
